[rtl/iad_pkg.sv]
// ----------------------------------------------------------------------------
// iad_pkg
// Shared types, step table and index adjustment for the IMA ADPCM decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package iad_pkg;

	localparam int unsigned IdxMax = 88;

	localparam logic signed [15:0] SampleMax = 16'sh7fff;
	localparam logic signed [15:0] SampleMin = 16'sh8000;

	// decoder state carried between nibbles
	typedef struct packed {
		logic signed [15:0] pred;
		logic [6:0]         pos;
	} state_t;

	// standard step size table; position 88 and every position above it read 32767
	function automatic logic [14:0] step_size(input logic [6:0] pos);
		logic [14:0] s;
		unique case (pos)
			7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;     7'd3:  s = 15'd10;
			7'd4:  s = 15'd11;    7'd5:  s = 15'd12;    7'd6:  s = 15'd13;    7'd7:  s = 15'd14;
			7'd8:  s = 15'd16;    7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
			7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;    7'd15: s = 15'd31;
			7'd16: s = 15'd34;    7'd17: s = 15'd37;    7'd18: s = 15'd41;    7'd19: s = 15'd45;
			7'd20: s = 15'd50;    7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
			7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;    7'd27: s = 15'd97;
			7'd28: s = 15'd107;   7'd29: s = 15'd118;   7'd30: s = 15'd130;   7'd31: s = 15'd143;
			7'd32: s = 15'd157;   7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
			7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;   7'd39: s = 15'd307;
			7'd40: s = 15'd337;   7'd41: s = 15'd371;   7'd42: s = 15'd408;   7'd43: s = 15'd449;
			7'd44: s = 15'd494;   7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
			7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;   7'd51: s = 15'd963;
			7'd52: s = 15'd1060;  7'd53: s = 15'd1166;  7'd54: s = 15'd1282;  7'd55: s = 15'd1411;
			7'd56: s = 15'd1552;  7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
			7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;  7'd63: s = 15'd3024;
			7'd64: s = 15'd3327;  7'd65: s = 15'd3660;  7'd66: s = 15'd4026;  7'd67: s = 15'd4428;
			7'd68: s = 15'd4871;  7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
			7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;  7'd75: s = 15'd9493;
			7'd76: s = 15'd10442; 7'd77: s = 15'd11487; 7'd78: s = 15'd12635; 7'd79: s = 15'd13899;
			7'd80: s = 15'd15289; 7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
			7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086; 7'd87: s = 15'd29794;
			default: s = 15'd32767;
		endcase
		return s;
	endfunction

	// index adjustment by code magnitude: -1 for 0..3, then +2, +4, +6, +8
	function automatic logic signed [4:0] idx_adjust(input logic [2:0] mag);
		logic signed [4:0] a;
		if (mag[2]) begin
			a = 5'(({3'b000, mag[1:0]} + 5'd1) << 1);
		end else begin
			a = -5'sd1;
		end
		return a;
	endfunction

endpackage

`default_nettype wire

[rtl/iad_nibble.sv]
// ----------------------------------------------------------------------------
// iad_nibble
// Combinational decode of one 4-bit code: predictor and step index update.
// ----------------------------------------------------------------------------
`default_nettype none

module iad_nibble (
	input  wire iad_pkg::state_t cur,
	input  wire logic [3:0]      code,
	output iad_pkg::state_t      nxt
);

	logic [6:0]         pos;
	logic [14:0]        step;
	logic [15:0]        delta;
	logic signed [17:0] sum;
	logic signed [7:0]  np;
	logic signed [15:0] pred_n;
	logic [6:0]         pos_n;

	// clamp position for the lookup
	assign pos  = (cur.pos > 7'(iad_pkg::IdxMax)) ? 7'(iad_pkg::IdxMax) : cur.pos;
	assign step = iad_pkg::step_size(pos);

	// difference from the magnitude bits
	always_comb begin
		delta = {4'b0000, step[14:3]};
		if (code[2]) delta = delta + {1'b0, step};
		if (code[1]) delta = delta + {2'b00, step[14:1]};
		if (code[0]) delta = delta + {3'b000, step[14:2]};
	end

	// signed add or subtract, then saturate
	always_comb begin
		if (code[3]) begin
			sum = {{2{cur.pred[15]}}, cur.pred} - $signed({2'b00, delta});
		end else begin
			sum = {{2{cur.pred[15]}}, cur.pred} + $signed({2'b00, delta});
		end
		if (sum > 18'sd32767) begin
			pred_n = iad_pkg::SampleMax;
		end else if (sum < -18'sd32768) begin
			pred_n = iad_pkg::SampleMin;
		end else begin
			pred_n = sum[15:0];
		end
	end

	// step index update with clamp
	always_comb begin
		np = $signed({1'b0, pos}) + 8'(iad_pkg::idx_adjust(code[2:0]));
		if (np < 8'sd0) begin
			pos_n = 7'd0;
		end else if (np > 8'sd88) begin
			pos_n = 7'(iad_pkg::IdxMax);
		end else begin
			pos_n = np[6:0];
		end
	end

	assign nxt = '{pred: pred_n, pos: pos_n};

endmodule

`default_nettype wire

[rtl/ima_adpcm_decoder_unit.sv]
// ----------------------------------------------------------------------------
// ima_adpcm_decoder_unit
// IMA ADPCM decoder, one byte in (two codes), two 16-bit samples out.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                              | tuser
//  s_axis  | in  | [7:0] data_byte                    | [0] restart
//  m_axis  | out | [15:0] sample_first, [31:16] second | -
//
//  one beat per cycle while m_axis is not stalled; each beat passes the input
//  register and then the output register; the predictor and step index chain
//  of both nibbles sits between those two registers and sets the clock period
//  reset clears the stage valids and the decoder state to zero
//  a stall on m_axis holds the output register; one more beat waits in the
//  input register before s_axis_tready drops
// ----------------------------------------------------------------------------
`default_nettype none

module ima_adpcm_decoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic        s_axis_tuser,   // [0] restart
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata    // [15:0] sample_first, [31:16] sample_second
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            restart_s1;
	logic            valid_s2;
	logic [31:0]     data_s2;
	iad_pkg::state_t state_q;
	iad_pkg::state_t st_in;
	iad_pkg::state_t st_mid;
	iad_pkg::state_t st_out;
	logic            out_free;
	logic            advance;

	// handshake between the two stages
	assign out_free      = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1    <= s_axis_tdata;
			restart_s1 <= s_axis_tuser;
		end
	end

	// restart clears the state ahead of the low nibble
	always_comb begin
		if (restart_s1) begin
			st_in = '0;
		end else begin
			st_in = state_q;
		end
	end

	iad_nibble u_lo (
		.cur  (st_in),
		.code (byte_s1[3:0]),
		.nxt  (st_mid)
	);

	iad_nibble u_hi (
		.cur  (st_mid),
		.code (byte_s1[7:4]),
		.nxt  (st_out)
	);

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= st_out;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {st_out.pred, st_mid.pred};
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;

endmodule

`default_nettype wire

[rtl/iad_checker.sv]
// ----------------------------------------------------------------------------
// iad_checker
// Port-level checks on the decoder's stream behavior, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module iad_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata
);

	// a stalled output beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output beat dropped while stalled");

	// a stalled output beat keeps its samples
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output samples changed while stalled");

	// input back-pressure only comes from a stalled output
	a_bp_source: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without an output stall");

	// an accepted input beat passes the input register and the output register when the output is free
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) ##1 (!m_axis_tvalid || m_axis_tready)
		|=> m_axis_tvalid)
		else $error("accepted beat did not reach the output");

endmodule

bind ima_adpcm_decoder_unit iad_checker u_iad_checker (.*);

`default_nettype wire
